FILE: design/vpa_pkg.sv
// Shared types, constants and the exponent table of the phase accumulator.
package vpa_pkg;

   localparam int PHASE_BITS_DEF = 32;

   localparam int PITCH_W   = 17;
   localparam int FRAC_W    = 12;
   localparam int MANT_W    = 31;
   localparam int RATE_W    = 34;
   localparam int STEP_W    = 40;
   localparam int STEP_HALF = 20;
   localparam int PROD_W    = 64;
   localparam int EXP_STEPS = 12;
   localparam int CNT_W     = 4;
   localparam int SHIFT_W   = 7;
   localparam int WORD_W    = 40;

   localparam logic signed [PITCH_W-1:0] REV_THRESHOLD = 17'sd20480;
   localparam logic signed [RATE_W-1:0]  HALF_Q16      = 34'sd32768;
   localparam logic [MANT_W-1:0]         MANT_ONE      = 31'h4000_0000;
   localparam logic [PROD_W-1:0]         ROUND_HALF    = 64'h2000_0000;

   // rate modes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_DERIV  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_RATE_MODE  = 2'd0;
   localparam logic [1:0] CSR_RESET_PC   = 2'd1;
   localparam logic [1:0] CSR_REV_SWITCH = 2'd2;
   localparam logic [1:0] CSR_STEP_SCALE = 2'd3;

   // shared multiplier operations
   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_EXP  = 2'd1;
   localparam logic [1:0] MUL_LO   = 2'd2;
   localparam logic [1:0] MUL_HI   = 2'd3;

   typedef struct packed {
      logic [1:0]        rate_mode;
      logic              reset_on_pitch_change;
      logic              reverse_switch;
      logic [STEP_W-1:0] step_scale;
   } cfg_type;

   // round(2^(2^i/4096) * 2^30)
   function automatic logic [MANT_W-1:0] exp_tab(input logic [CNT_W-1:0] idx);
      logic [MANT_W-1:0] val;
      unique case (idx)
         4'd0:    val = 31'd1073923544;
         4'd1:    val = 31'd1074105294;
         4'd2:    val = 31'd1074468888;
         4'd3:    val = 31'd1075196443;
         4'd4:    val = 31'd1076653033;
         4'd5:    val = 31'd1079572136;
         4'd6:    val = 31'd1085434106;
         4'd7:    val = 31'd1097253708;
         4'd8:    val = 31'd1121280436;
         4'd9:    val = 31'd1170923762;
         4'd10:   val = 31'd1276901417;
         4'd11:   val = 31'd1518500250;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: design/vpa_csr.sv
// Configuration register file of the phase accumulator.
module vpa_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [vpa_pkg::STEP_W-1:0]    csr_data,
   output vpa_pkg::cfg_type              cfg
);

   vpa_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_mode             <= vpa_pkg::MODE_LINEAR;
         cfg_ff.reset_on_pitch_change <= 1'b0;
         cfg_ff.reverse_switch        <= 1'b0;
         cfg_ff.step_scale            <= 40'd1048576;
      end else if (csr_valid) begin
         unique case (csr_index)
            vpa_pkg::CSR_RATE_MODE:  cfg_ff.rate_mode             <= csr_data[1:0];
            vpa_pkg::CSR_RESET_PC:   cfg_ff.reset_on_pitch_change <= csr_data[0];
            vpa_pkg::CSR_REV_SWITCH: cfg_ff.reverse_switch        <= csr_data[0];
            vpa_pkg::CSR_STEP_SCALE: cfg_ff.step_scale            <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

FILE: design/vpa_mul_unit.sv
// Shared signed multiplier with operand selection for exponent and step scaling.
module vpa_mul_unit (
   input  logic [1:0]                          op,
   input  logic [vpa_pkg::MANT_W-1:0]          mant,
   input  logic [vpa_pkg::CNT_W-1:0]           bit_idx,
   input  logic signed [vpa_pkg::RATE_W-1:0]   rate,
   input  logic [vpa_pkg::STEP_W-1:0]          step_scale,
   output logic [vpa_pkg::PROD_W-1:0]          product
);

   logic signed [vpa_pkg::RATE_W:0]   opa;
   logic [vpa_pkg::MANT_W-1:0]        opb;
   logic signed [vpa_pkg::RATE_W+vpa_pkg::MANT_W+1:0] full;

   always_comb begin
      unique case (op)
         vpa_pkg::MUL_EXP: begin
            opa = $signed({4'b0, mant});
            opb = vpa_pkg::exp_tab(bit_idx);
         end
         vpa_pkg::MUL_LO: begin
            opa = $signed({rate[vpa_pkg::RATE_W-1], rate});
            opb = {11'b0, step_scale[vpa_pkg::STEP_HALF-1:0]};
         end
         vpa_pkg::MUL_HI: begin
            opa = $signed({rate[vpa_pkg::RATE_W-1], rate});
            opb = {11'b0, step_scale[vpa_pkg::STEP_W-1:vpa_pkg::STEP_HALF]};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      full    = opa * $signed({1'b0, opb});
      product = full[vpa_pkg::PROD_W-1:0];
   end

endmodule

FILE: design/voct_phase_accumulator_core.sv
// Exponential-FM phase accumulator: sequencer, state and output register.
//
// One request word per audio sample carries pitch and reverse voltages (signed
// Q4.12), the reverse-jack flag and the link flag. Each request yields exactly
// one response word: the 32-bit phase (full range = 10 units), the reverse
// decision and the link light.
// A linked word goes from acceptance to the response register in these steps:
// 12 passes through the shared multiplier for the fractional exponent (one per
// fraction bit), a shift/sign step, two multiplier passes for the 40-bit step
// scale, a sum step, an accumulate step and the output load. An unlinked word
// goes straight to the output load. req_tready is high only while the sequencer
// is idle, so no new word is taken while one is in flight; the next word can be
// accepted in the cycle after the previous response is loaded.
// The response register holds its word while rsp_tready is low; a finished
// result waits in the sequencer until the register frees up, and a new request
// may be accepted while the previous response still sits in the register.
// Reset clears the phase and remembered pitch and loads register defaults
// (linear mode, step scale 2^20). Configuration writes are taken every cycle
// and must only be issued while the block is idle.
module voct_phase_accumulator_core #(
   parameter int PHASE_BITS = vpa_pkg::PHASE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [16:0] pitch_volts, [33:17] reverse_volts, [34] reverse_jack_connected,
   // [35] linked, [39:36] zero
   input  logic [39:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] phase, [32] reverse_active, [33] link_light, [39:34] zero
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [39:0]  csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXP   = 4'd1;
   localparam logic [3:0] ST_SHIFT = 4'd2;
   localparam logic [3:0] ST_MLO   = 4'd3;
   localparam logic [3:0] ST_MHI   = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_UPD   = 4'd6;
   localparam logic [3:0] ST_OUT   = 4'd7;

   localparam int PW = vpa_pkg::PITCH_W;

   vpa_pkg::cfg_type cfg;

   logic [3:0]                          state_ff, state_in;
   logic [vpa_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [vpa_pkg::FRAC_W-1:0]          frac_ff, frac_in;
   logic signed [vpa_pkg::SHIFT_W-1:0]  shift_ff, shift_in;
   logic [vpa_pkg::MANT_W-1:0]          mant_ff, mant_in;
   logic signed [vpa_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [vpa_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [vpa_pkg::PROD_W-1:0]          sum_ff, sum_in;
   logic                                rev_ff, rev_in;
   logic                                link_ff, link_in;
   logic [PHASE_BITS-1:0]               phase_acc_ff, phase_acc_in;
   logic [PW-1:0]                       pitch_mem_ff, pitch_mem_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [vpa_pkg::WORD_W-1:0]          rsp_data_ff, rsp_data_in;

   logic                                req_fire;
   logic                                rsp_free;
   logic [1:0]                          mul_op;
   logic [vpa_pkg::PROD_W-1:0]          product;
   logic [vpa_pkg::PROD_W-1:0]          rounded;
   logic signed [PW-1:0]                rev_volts_in;
   logic signed [vpa_pkg::SHIFT_W-1:0]  octave;
   logic signed [vpa_pkg::SHIFT_W-1:0]  neg_shift;
   logic [31:0]                         mag;
   logic signed [vpa_pkg::RATE_W-1:0]   mag_signed;
   logic [31:0]                         phase_out;

   vpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vpa_mul_unit u_mul (
      .op         (mul_op),
      .mant       (mant_ff),
      .bit_idx    (cnt_ff),
      .rate       (rate_ff),
      .step_scale (cfg.step_scale),
      .product    (product)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rev_volts_in = $signed(req_tdata[2*PW-1:PW]);
   assign octave       = $signed({{2{req_tdata[PW-1]}}, req_tdata[PW-1:vpa_pkg::FRAC_W]});
   assign rounded      = product + vpa_pkg::ROUND_HALF;
   assign neg_shift    = -shift_ff;

   generate
      if (PHASE_BITS >= 32) begin : g_phase_top
         assign phase_out = phase_acc_ff[PHASE_BITS-1 -: 32];
      end else begin : g_phase_fill
         assign phase_out = {phase_acc_ff, {(32-PHASE_BITS){1'b0}}};
      end
   endgenerate

   always_comb begin
      unique case (state_ff)
         ST_EXP:  mul_op = vpa_pkg::MUL_EXP;
         ST_MLO:  mul_op = vpa_pkg::MUL_LO;
         ST_MHI:  mul_op = vpa_pkg::MUL_HI;
         default: mul_op = vpa_pkg::MUL_NONE;
      endcase
   end

   // magnitude 2^(v/4096 + extra) in Q.16; shift range is -31 to +1
   always_comb begin
      if (shift_ff > 0) begin
         mag = {mant_ff, 1'b0};
      end else begin
         mag = {1'b0, mant_ff} >> neg_shift[4:0];
      end
      mag_signed = rev_ff ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      frac_in       = frac_ff;
      shift_in      = shift_ff;
      mant_in       = mant_ff;
      rate_in       = rate_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      rev_in        = rev_ff;
      link_in       = link_ff;
      phase_acc_in  = phase_acc_ff;
      pitch_mem_in  = pitch_mem_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rev_in   = req_tdata[2*PW] ? (rev_volts_in >= vpa_pkg::REV_THRESHOLD)
                                          : cfg.reverse_switch;
               link_in  = req_tdata[2*PW+1];
               frac_in  = req_tdata[vpa_pkg::FRAC_W-1:0];
               shift_in = octave - 7'sd14
                          - ((cfg.rate_mode == vpa_pkg::MODE_DERIV) ? 7'sd1 : 7'sd0);
               mant_in  = vpa_pkg::MANT_ONE;
               cnt_in   = '0;
               if (req_tdata[2*PW+1]) begin
                  // in reset mode, clear phase before this sample's step when pitch moved
                  if (cfg.reset_on_pitch_change && (req_tdata[PW-1:0] != pitch_mem_ff)) begin
                     phase_acc_in = '0;
                     pitch_mem_in = req_tdata[PW-1:0];
                  end
                  state_in = ST_EXP;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_EXP: begin
            if (frac_ff[cnt_ff]) begin
               mant_in = rounded[vpa_pkg::MANT_W+29:30];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == vpa_pkg::CNT_W'(vpa_pkg::EXP_STEPS - 1)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            case (cfg.rate_mode)
               vpa_pkg::MODE_LINEAR: rate_in = mag_signed;
               vpa_pkg::MODE_DERIV:  rate_in = mag_signed - vpa_pkg::HALF_Q16;
               default:              rate_in = '0;
            endcase
            state_in = ST_MLO;
         end
         ST_MLO: begin
            prod_in  = product;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            sum_in   = prod_ff;
            prod_in  = product;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sum_ff + {prod_ff[vpa_pkg::PROD_W-vpa_pkg::STEP_HALF-1:0],
                                 {vpa_pkg::STEP_HALF{1'b0}}};
            state_in = ST_UPD;
         end
         ST_UPD: begin
            phase_acc_in = phase_acc_ff + sum_ff[vpa_pkg::PROD_W-1 -: PHASE_BITS];
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {6'b0, link_ff, rev_ff, phase_out};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         phase_acc_ff  <= '0;
         pitch_mem_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         phase_acc_ff  <= phase_acc_in;
         pitch_mem_ff  <= pitch_mem_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff     <= frac_in;
      shift_ff    <= shift_in;
      mant_ff     <= mant_in;
      rate_ff     <= rate_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rev_ff      <= rev_in;
      link_ff     <= link_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_unlinked_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tdata[2*PW+1]) |=> (phase_acc_ff == $past(phase_acc_ff)))
      else $error("phase changed on an unlinked word");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !$past(rsp_tvalid_ff)) |-> ($past(state_ff) == ST_OUT))
      else $error("response loaded outside output state");

   a_exp_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP) |-> (cnt_ff < vpa_pkg::CNT_W'(vpa_pkg::EXP_STEPS)))
      else $error("exponent step count out of range");

   a_phase_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPD && !req_fire) |=> (phase_acc_ff == $past(phase_acc_ff)))
      else $error("phase changed outside accumulate or accept");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the phase accumulator core: directed plan, then random phases.
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 24;
   localparam int TAIL_CYCLES     = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 231;
   localparam int MAX_PRINTS      = 40;

   // rate mode code the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [39:0] STEP_DEFAULT = 40'd1048576;
   localparam logic [39:0] STEP_MAX     = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] phase;
      logic        reverse_active;
      logic        link_light;
   } rsp_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      vpa_pkg::cfg_type   cfg;
      logic signed [16:0] pitch;
      logic signed [16:0] rvolts;
      logic               jack;
      logic               link;
      logic               typed;
      rsp_word_type       typed_word;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [39:0] csr_data = '0;

   // predictor state and register copy, at reset values
   logic [31:0]        acc_phase    = '0;
   logic signed [16:0] held_pitch   = '0;
   logic [1:0]         acc_mode     = vpa_pkg::MODE_LINEAR;
   logic               acc_reset_pc = 1'b0;
   logic               acc_rev_sw   = 1'b0;
   logic [39:0]        acc_step     = STEP_DEFAULT;

   // round(2^(2^i/4096) * 2^30)
   logic [63:0] frac_gain [0:11] = '{
      64'd1073923544, 64'd1074105294, 64'd1074468888, 64'd1075196443,
      64'd1076653033, 64'd1079572136, 64'd1085434106, 64'd1097253708,
      64'd1121280436, 64'd1170923762, 64'd1276901417, 64'd1518500250
   };

   rsp_word_type phase_words_owed [$];
   plan_row_type directed_plan [$];

   int err_count    = 0;
   int rsp_seen     = 0;
   int cycle_count  = 0;
   int gap_pct      = 0;
   int stall_pct    = 0;
   int hold_off_ask = 0;
   int hold_left    = 0;

   voct_phase_accumulator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // 2^(v/4096 + extra) in Q.16
   function automatic logic [63:0] pitch_to_rate(input logic signed [16:0] v, input int extra);
      int          biased;
      int          shift;
      logic [11:0] frac;
      logic [63:0] mant;
      biased = int'(v) + 65536;
      frac = biased[11:0];
      shift = (biased >> 12) - 16 - 14 + extra;
      mant = 64'd1 << 30;
      for (int i = 0; i < 12; i++) begin
         if (frac[i]) begin
            mant = (mant * frac_gain[i] + (64'd1 << 29)) >> 30;
         end
      end
      if (shift >= 0) begin
         mant = mant << shift;
      end else begin
         mant = mant >> (-shift);
      end
      return mant;
   endfunction

   function automatic rsp_word_type advance_phase(input logic signed [16:0] pitch,
                                                  input logic signed [16:0] rvolts,
                                                  input logic jack, input logic link);
      rsp_word_type       w;
      logic               rev;
      logic signed [63:0] rate;
      logic [63:0]        prod;
      rev = jack ? (rvolts >= vpa_pkg::REV_THRESHOLD) : acc_rev_sw;
      if (link) begin
         if (acc_reset_pc && pitch != held_pitch) begin
            acc_phase = '0;
            held_pitch = pitch;
         end
         rate = '0;
         if (acc_mode == vpa_pkg::MODE_LINEAR) begin
            rate = pitch_to_rate(pitch, 0);
            if (rev) rate = -rate;
         end else if (acc_mode == vpa_pkg::MODE_DERIV) begin
            rate = pitch_to_rate(pitch, -1);
            if (rev) rate = -rate;
            rate = rate - vpa_pkg::HALF_Q16;
         end
         prod = $unsigned(rate) * {24'd0, acc_step};
         acc_phase = acc_phase + prod[63:32];
      end
      w.phase = acc_phase;
      w.reverse_active = rev;
      w.link_light = link;
      return w;
   endfunction

   function automatic plan_row_type word_row(input int pitch, input int rvolts,
                                             input logic jack, input logic link);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.pitch = 17'(pitch);
      r.rvolts = 17'(rvolts);
      r.jack = jack;
      r.link = link;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input int pitch, input int rvolts,
                                              input logic jack, input logic link,
                                              input logic [31:0] phase, input logic rev);
      plan_row_type r;
      r = word_row(pitch, rvolts, jack, link);
      r.typed = 1'b1;
      r.typed_word.phase = phase;
      r.typed_word.reverse_active = rev;
      r.typed_word.link_light = link;
      return r;
   endfunction

   function automatic plan_row_type cfg_row(input logic [1:0] mode, input logic reset_pc,
                                            input logic rev_sw, input logic [39:0] step);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.cfg.rate_mode = mode;
      r.cfg.reset_on_pitch_change = reset_pc;
      r.cfg.reverse_switch = rev_sw;
      r.cfg.step_scale = step;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      err_count++;
      if (err_count <= MAX_PRINTS) begin
         $display("mismatch at response %0d, %s: got %0h want %0h", rsp_seen, what, got, want);
      end
   endtask

   // lower valid and hold until every owed word is back
   task automatic drain_words();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (phase_words_owed.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [39:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         vpa_pkg::CSR_RATE_MODE:  acc_mode = value[1:0];
         vpa_pkg::CSR_RESET_PC:   acc_reset_pc = value[0];
         vpa_pkg::CSR_REV_SWITCH: acc_rev_sw = value[0];
         vpa_pkg::CSR_STEP_SCALE: acc_step = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input vpa_pkg::cfg_type c);
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(vpa_pkg::CSR_RATE_MODE, 40'(c.rate_mode));
      write_reg(vpa_pkg::CSR_RESET_PC, 40'(c.reset_on_pitch_change));
      write_reg(vpa_pkg::CSR_REV_SWITCH, 40'(c.reverse_switch));
      write_reg(vpa_pkg::CSR_STEP_SCALE, c.step_scale);
      csr_valid <= 1'b0;
   endtask

   task automatic offer_word(input logic signed [16:0] pitch, input logic signed [16:0] rvolts,
                             input logic jack, input logic link,
                             input logic typed, input rsp_word_type typed_word);
      rsp_word_type due;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, link, jack, rvolts, pitch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = advance_phase(pitch, rvolts, jack, link);
      phase_words_owed.push_back(typed ? typed_word : due);
   endtask

   // receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_ask != 0) begin
         hold_left = hold_off_ask;
         hold_off_ask = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.phase = rsp_tdata[31:0];
         got.reverse_active = rsp_tdata[32];
         got.link_light = rsp_tdata[33];
         if (phase_words_owed.size() == 0) begin
            report_mismatch("word with none owed", 64'(rsp_tdata), '0);
         end else begin
            want = phase_words_owed.pop_front();
            if (got.phase !== want.phase)
               report_mismatch("phase", 64'(got.phase), 64'(want.phase));
            if (got.reverse_active !== want.reverse_active)
               report_mismatch("reverse_active", 64'(got.reverse_active),
                               64'(want.reverse_active));
            if (got.link_light !== want.link_light)
               report_mismatch("link_light", 64'(got.link_light), 64'(want.link_light));
         end
         rsp_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      vpa_pkg::cfg_type   c;
      plan_row_type       row;
      logic signed [16:0] pitch_now;
      logic signed [16:0] rv;
      rsp_word_type       none;

      none = '0;
      pitch_now = '0;

      // after reset: linear mode, one volt per octave, step 2^20 gives 16 per unit rate
      directed_plan.push_back(typed_row(0, 0, 1'b0, 1'b1, 32'd16, 1'b0));
      directed_plan.push_back(typed_row(0, 0, 1'b0, 1'b1, 32'd32, 1'b0));
      directed_plan.push_back(typed_row(4096, 0, 1'b0, 1'b1, 32'd64, 1'b0));
      directed_plan.push_back(typed_row(0, 0, 1'b0, 1'b0, 32'd64, 1'b0));
      directed_plan.push_back(typed_row(40960, 0, 1'b0, 1'b1, 32'd16448, 1'b0));
      directed_plan.push_back(word_row(-40960, 0, 1'b0, 1'b1));
      // pitch beyond ten volts, reverse gate right at and below threshold
      directed_plan.push_back(word_row(65535, 20480, 1'b1, 1'b1));
      directed_plan.push_back(word_row(-65536, 20479, 1'b1, 1'b1));
      directed_plan.push_back(word_row(4095, -65536, 1'b1, 1'b1));
      directed_plan.push_back(word_row(-1, 65535, 1'b1, 1'b1));
      directed_plan.push_back(cfg_row(vpa_pkg::MODE_LINEAR, 1'b0, 1'b1, STEP_DEFAULT));
      directed_plan.push_back(word_row(8192, 0, 1'b0, 1'b1));
      directed_plan.push_back(word_row(8192, 40960, 1'b1, 1'b0));
      directed_plan.push_back(cfg_row(vpa_pkg::MODE_DERIV, 1'b0, 1'b0, STEP_MAX));
      directed_plan.push_back(word_row(0, 0, 1'b0, 1'b1));
      directed_plan.push_back(word_row(4096, 20480, 1'b1, 1'b1));
      directed_plan.push_back(word_row(-40960, 0, 1'b0, 1'b1));
      directed_plan.push_back(cfg_row(MODE_UNUSED, 1'b0, 1'b0, STEP_DEFAULT));
      directed_plan.push_back(word_row(12288, 0, 1'b0, 1'b1));
      directed_plan.push_back(cfg_row(vpa_pkg::MODE_NONE, 1'b1, 1'b0, STEP_DEFAULT));
      directed_plan.push_back(word_row(100, 0, 1'b0, 1'b1));
      // reset mode: same pitch keeps adding, a new pitch clears, unlinked remembers nothing
      directed_plan.push_back(cfg_row(vpa_pkg::MODE_LINEAR, 1'b1, 1'b0, STEP_DEFAULT));
      directed_plan.push_back(word_row(100, 0, 1'b0, 1'b1));
      directed_plan.push_back(word_row(100, 0, 1'b0, 1'b1));
      directed_plan.push_back(word_row(200, 0, 1'b0, 1'b1));
      directed_plan.push_back(word_row(300, 0, 1'b0, 1'b0));
      directed_plan.push_back(word_row(200, 0, 1'b0, 1'b1));
      directed_plan.push_back(cfg_row(vpa_pkg::MODE_LINEAR, 1'b0, 1'b0, 40'd0));
      directed_plan.push_back(word_row(20000, 0, 1'b0, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR) begin
            apply_config(row.cfg);
         end else begin
            offer_word(row.pitch, row.rvolts, row.jack, row.link, row.typed, row.typed_word);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph) inside
            0, 2, 6: c.rate_mode = vpa_pkg::MODE_LINEAR;
            1, 4, 7: c.rate_mode = vpa_pkg::MODE_DERIV;
            3:       c.rate_mode = vpa_pkg::MODE_NONE;
            default: c.rate_mode = MODE_UNUSED;
         endcase
         c.reset_on_pitch_change = ph[0];
         c.reverse_switch = 1'($urandom_range(0, 1));
         case (ph) inside
            0, 6:    c.step_scale = STEP_MAX;
            5:       c.step_scale = 40'd0;
            2:       c.step_scale = STEP_DEFAULT;
            3:       c.step_scale = 40'd1 << $urandom_range(0, 39);
            default: c.step_scale = 40'({$urandom, $urandom});
         endcase
         apply_config(c);

         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 72; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 72; end
            default: begin gap_pct = 16; stall_pct = 16; end
         endcase

         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            // sender pauses until the block has returned everything
            if (ph == 1 && k == 100) drain_words();
            // receiver holds off while words keep coming, so the input stalls
            if (ph == 2 && k == 40) hold_off_ask = 240;

            // runs of one pitch dominate so reset mode gets to accumulate
            case ($urandom_range(0, 5)) inside
               0, 1, 2: ;
               3: pitch_now = 17'(int'($urandom_range(0, 81920)) - 40960);
               4: pitch_now = 17'($urandom);
               default: pitch_now = 17'((int'($urandom_range(0, 20)) - 10) * 4096);
            endcase
            if ($urandom_range(0, 1))
               rv = 17'($urandom);
            else
               rv = 17'(int'($urandom_range(20470, 20490)));
            offer_word(pitch_now, rv, 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 99) < 88), 1'b0, none);
         end
      end

      drain_words();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
